// File: src/plc_pkg.sv
`timescale 1ns / 1ps
// Package for the parametric line clipper: widths, codes and the types that
// travel between the pipeline stages. Used by every module of the block.
package plc_pkg;

  localparam int CoordWidth = 16;
  localparam int FracBits   = 20;
  localparam int DivSteps   = 4;
  localparam int DivStages  = (FracBits + DivSteps - 1) / DivSteps;
  localparam int DiffWidth  = CoordWidth + 1;
  localparam int TWidth     = FracBits + 1;
  localparam int ProdWidth  = TWidth + DiffWidth;
  localparam int NumEdges   = 4;
  localparam int EdgeTop    = 0;
  localparam int EdgeBottom = 1;
  localparam int EdgeRight  = 2;
  localparam int EdgeLeft   = 3;
  localparam int AddrWidth  = 4;
  localparam int DataWidth  = 32;

  localparam logic [1:0] RegLeft   = 2'd0;
  localparam logic [1:0] RegRight  = 2'd1;
  localparam logic [1:0] RegTop    = 2'd2;
  localparam logic [1:0] RegBottom = 2'd3;

  localparam logic [3:0] CodeTop    = 4'd8;
  localparam logic [3:0] CodeBottom = 4'd4;
  localparam logic [3:0] CodeRight  = 4'd2;
  localparam logic [3:0] CodeLeft   = 4'd1;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic [DiffWidth-1:0]         mag_t;
  typedef logic [TWidth-1:0]            tval_t;

  localparam tval_t TOne = tval_t'(1) << FracBits;

  typedef enum logic [2:0] {
    OC_TRIV_ACCEPT = 3'd0,
    OC_TRIV_REJECT = 3'd1,
    OC_ZERO_LENGTH = 3'd2,
    OC_CLIP_ACCEPT = 3'd3,
    OC_CLIP_EMPTY  = 3'd4
  } outcome_e;

  typedef enum logic [1:0] {
    DM_ZERO = 2'd0,
    DM_ONE  = 2'd1,
    DM_DIV  = 2'd2
  } div_mode_e;

  typedef struct packed {
    div_mode_e mode;
    mag_t      rem;
    mag_t      den;
  } div_in_t;

  typedef struct packed {
    outcome_e              outcome;
    coord_t                x0;
    coord_t                y0;
    coord_t                x1;
    coord_t                y1;
    diff_t                 dx;
    diff_t                 dy;
    logic [NumEdges-1:0]   skip;
    logic [NumEdges-1:0]   is_exit;
  } side_t;

endpackage

// File: src/plc_front.sv
`timescale 1ns / 1ps
// Front stage logic: outcodes, deltas and the per-edge ratio setup.
// Depends on plc_pkg.
module plc_front import plc_pkg::*; (
  input  coord_t                      start_x_i,
  input  coord_t                      start_y_i,
  input  coord_t                      end_x_i,
  input  coord_t                      end_y_i,
  input  coord_t                      left_i,
  input  coord_t                      right_i,
  input  coord_t                      top_i,
  input  coord_t                      bottom_i,
  output side_t                       side_o,
  output div_in_t [NumEdges-1:0]      div_o
);

  logic [3:0] c0, c1;
  diff_t      dx, dy;
  diff_t      num [NumEdges];
  diff_t      den [NumEdges];

  function automatic logic [3:0] outcode(coord_t x, coord_t y, coord_t l, coord_t r,
                                         coord_t t, coord_t b);
    logic [3:0] c;
    c = '0;
    if (y > t) c = c | CodeTop;
    else if (y < b) c = c | CodeBottom;
    if (x > r) c = c | CodeRight;
    else if (x < l) c = c | CodeLeft;
    return c;
  endfunction

  assign c0 = outcode(start_x_i, start_y_i, left_i, right_i, top_i, bottom_i);
  assign c1 = outcode(end_x_i, end_y_i, left_i, right_i, top_i, bottom_i);
  assign dx = diff_t'(end_x_i) - diff_t'(start_x_i);
  assign dy = diff_t'(end_y_i) - diff_t'(start_y_i);

  assign num[EdgeTop]    = diff_t'(top_i) - diff_t'(start_y_i);
  assign num[EdgeBottom] = diff_t'(bottom_i) - diff_t'(start_y_i);
  assign num[EdgeRight]  = diff_t'(right_i) - diff_t'(start_x_i);
  assign num[EdgeLeft]   = diff_t'(left_i) - diff_t'(start_x_i);
  assign den[EdgeTop]    = dy;
  assign den[EdgeBottom] = dy;
  assign den[EdgeRight]  = dx;
  assign den[EdgeLeft]   = dx;

  always_comb begin
    side_o.x0 = start_x_i;
    side_o.y0 = start_y_i;
    side_o.x1 = end_x_i;
    side_o.y1 = end_y_i;
    side_o.dx = dx;
    side_o.dy = dy;
    if ((c0 | c1) == 4'd0) begin
      side_o.outcome = OC_TRIV_ACCEPT;
    end else if ((c0 & c1) != 4'd0) begin
      side_o.outcome = OC_TRIV_REJECT;
    end else if (dx == '0 && dy == '0) begin
      side_o.outcome = OC_ZERO_LENGTH;
    end else begin
      side_o.outcome = OC_CLIP_ACCEPT;
    end
  end

  for (genvar e = 0; e < NumEdges; e++) begin : g_edge
    logic neg_n, neg_d;
    mag_t an, ad;
    assign neg_n = num[e][DiffWidth-1];
    assign neg_d = den[e][DiffWidth-1];
    assign an    = neg_n ? mag_t'(-num[e]) : mag_t'(num[e]);
    assign ad    = neg_d ? mag_t'(-den[e]) : mag_t'(den[e]);
    assign side_o.skip[e]    = (den[e] == '0);
    assign side_o.is_exit[e] = (e == EdgeTop || e == EdgeRight) ? !neg_d : neg_d;
    always_comb begin
      div_o[e].rem = an;
      div_o[e].den = ad;
      if (num[e] == '0 || neg_n != neg_d) begin
        div_o[e].mode = DM_ZERO;
      end else if (an >= ad) begin
        div_o[e].mode = DM_ONE;
      end else begin
        div_o[e].mode = DM_DIV;
      end
    end
  end

endmodule

// File: src/plc_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider giving a saturated fraction per edge,
// DivSteps (four) quotient bits per stage. Depends on plc_pkg.
module plc_div import plc_pkg::*; (
  input  logic    clk_i,
  input  logic    en_i,
  input  div_in_t div_i,
  output tval_t   t_o
);

  mag_t                rem_in  [DivStages];
  mag_t                den_in  [DivStages];
  logic [FracBits-1:0] quo_in  [DivStages];
  div_mode_e           mode_in [DivStages];
  mag_t                rem_d   [DivStages];
  logic [FracBits-1:0] quo_d   [DivStages];
  mag_t                rem_q   [DivStages];
  mag_t                den_q   [DivStages];
  logic [FracBits-1:0] quo_q   [DivStages];
  div_mode_e           mode_q  [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stg
    if (s == 0) begin : g_first
      assign rem_in[s]  = div_i.rem;
      assign den_in[s]  = div_i.den;
      assign quo_in[s]  = '0;
      assign mode_in[s] = div_i.mode;
    end else begin : g_next
      assign rem_in[s]  = rem_q[s-1];
      assign den_in[s]  = den_q[s-1];
      assign quo_in[s]  = quo_q[s-1];
      assign mode_in[s] = mode_q[s-1];
    end

    always_comb begin
      logic [DiffWidth:0]  r;
      logic [DiffWidth:0]  sh;
      logic                ge;
      logic [FracBits-1:0] q;
      r  = {1'b0, rem_in[s]};
      q  = quo_in[s];
      sh = '0;
      ge = 1'b0;
      for (int k = 0; k < DivSteps; k++) begin
        if (s * DivSteps + k < FracBits) begin
          sh = {r[DiffWidth-1:0], 1'b0};
          ge = (sh >= {1'b0, den_in[s]});
          r  = ge ? sh - {1'b0, den_in[s]} : sh;
          q  = {q[FracBits-2:0], ge};
        end
      end
      rem_d[s] = r[DiffWidth-1:0];
      quo_d[s] = q;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d[s];
        den_q[s]  <= den_in[s];
        quo_q[s]  <= quo_d[s];
        mode_q[s] <= mode_in[s];
      end
    end
  end

  always_comb begin
    unique case (mode_q[DivStages-1])
      DM_ONE:  t_o = TOne;
      DM_DIV:  t_o = {1'b0, quo_q[DivStages-1]};
      default: t_o = '0;
    endcase
  end

endmodule

// File: src/plc_lerp.sv
`timescale 1ns / 1ps
// Point interpolation start + t * delta: a registered product followed by
// the add with truncation toward zero. Depends on plc_pkg.
module plc_lerp import plc_pkg::*; (
  input  logic   clk_i,
  input  logic   en_i,
  input  coord_t s_i,
  input  diff_t  d_i,
  input  tval_t  t_i,
  output coord_t v_o
);

  mag_t                   ad;
  logic [ProdWidth-1:0]   prod_d, prod_q;
  coord_t                 s_q;
  logic                   neg_q;
  logic signed [DiffWidth+1:0] base, qv, sum, v;
  logic                   frac;

  assign ad     = d_i[DiffWidth-1] ? mag_t'(-d_i) : mag_t'(d_i);
  assign prod_d = ProdWidth'(t_i) * ProdWidth'(ad);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      s_q    <= s_i;
      neg_q  <= d_i[DiffWidth-1];
    end
  end

  assign base = (DiffWidth+2)'(s_q);
  assign qv   = (DiffWidth+2)'({1'b0, prod_q[ProdWidth-1:FracBits]});
  assign frac = |prod_q[FracBits-1:0];
  assign sum  = neg_q ? base - qv : base + qv;

  always_comb begin
    v = sum;
    if (frac && !neg_q && sum[DiffWidth+1]) begin
      v = sum + (DiffWidth+2)'(1);
    end else if (frac && neg_q && !sum[DiffWidth+1] && sum != '0) begin
      v = sum - (DiffWidth+2)'(1);
    end
  end

  assign v_o = v[CoordWidth-1:0];

endmodule

// File: src/parametric_line_clipper_core.sv
`timescale 1ns / 1ps
// Top level of the parametric line clipper: configuration registers and the
// pipeline control. Depends on plc_pkg, plc_front, plc_div and plc_lerp.
//
// Each input item is one line segment, taken when in_valid_i is high and
// in_stall_o is low. Each item gives exactly one result item on the output
// channel, taken when out_valid_o is high and out_stall_i is low.
// The pipeline has DivStages + 4 register stages (nine at 20 fraction bits).
// The depth is set by the divider, which resolves four quotient bits per
// stage. A new item may enter in every cycle in which in_stall_o is low, so
// the throughput is one item per cycle while the output is not stalled.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall_o is raised in the same cycle; no item is lost or repeated.
// Reset empties the pipeline and loads the window registers with left -120,
// right 120, top 120 and bottom -120. The window is written through the
// APB-style port at byte addresses 0, 4, 8 and 12 and should only change
// while no item is in flight.
module parametric_line_clipper_core import plc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  coord_t               start_x_i,
  input  coord_t               start_y_i,
  input  coord_t               end_x_i,
  input  coord_t               end_y_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 accepted_o,
  output logic [2:0]           outcome_o,
  output coord_t               clipped_start_x_o,
  output coord_t               clipped_start_y_o,
  output coord_t               clipped_end_x_o,
  output coord_t               clipped_end_y_o
);

  coord_t left_q, right_q, top_q, bottom_q;
  logic   wr_en;
  logic   en;

  side_t                  side_f;
  div_in_t [NumEdges-1:0] div_f;
  side_t                  side1_q;
  div_in_t [NumEdges-1:0] div1_q;
  logic                   v1_q;
  side_t                  sided_q [DivStages];
  logic                   vd_q    [DivStages];
  tval_t                  t_div   [NumEdges];
  tval_t                  te_d, tl_d, te_q, tl_q;
  outcome_e               oc_sel;
  side_t                  side_sel;
  side_t                  sides_q, sidem_q;
  logic                   vs_q, vm_q;
  coord_t                 lerp_v [4];
  logic                   acc_d;
  coord_t                 csx_d, csy_d, cex_d, cey_d;
  logic                   out_valid_q, accepted_q;
  outcome_e               outcome_q;
  coord_t                 csx_q, csy_q, cex_q, cey_q;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= -coord_t'(120);
      right_q  <= coord_t'(120);
      top_q    <= coord_t'(120);
      bottom_q <= -coord_t'(120);
    end else if (wr_en) begin
      unique case (paddr[3:2])
        RegLeft:   left_q   <= pwdata[CoordWidth-1:0];
        RegRight:  right_q  <= pwdata[CoordWidth-1:0];
        RegTop:    top_q    <= pwdata[CoordWidth-1:0];
        RegBottom: bottom_q <= pwdata[CoordWidth-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegLeft:   prdata = DataWidth'(left_q);
      RegRight:  prdata = DataWidth'(right_q);
      RegTop:    prdata = DataWidth'(top_q);
      RegBottom: prdata = DataWidth'(bottom_q);
      default:   prdata = '0;
    endcase
  end

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  plc_front u_front (
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .left_i    (left_q),
    .right_i   (right_q),
    .top_i     (top_q),
    .bottom_i  (bottom_q),
    .side_o    (side_f),
    .div_o     (div_f)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q <= side_f;
      div1_q  <= div_f;
    end
  end

  for (genvar e = 0; e < NumEdges; e++) begin : g_div
    plc_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .div_i (div1_q[e]),
      .t_o   (t_div[e])
    );
  end

  for (genvar s = 0; s < DivStages; s++) begin : g_dly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[s] <= 1'b0;
      end else if (en) begin
        vd_q[s] <= (s == 0) ? v1_q : vd_q[(s == 0) ? 0 : s-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sided_q[s] <= (s == 0) ? side1_q : sided_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  always_comb begin
    te_d = '0;
    tl_d = TOne;
    for (int e = 0; e < NumEdges; e++) begin
      if (!sided_q[DivStages-1].skip[e]) begin
        if (sided_q[DivStages-1].is_exit[e]) begin
          if (t_div[e] < tl_d) tl_d = t_div[e];
        end else begin
          if (t_div[e] > te_d) te_d = t_div[e];
        end
      end
    end
    oc_sel = sided_q[DivStages-1].outcome;
    if (oc_sel == OC_CLIP_ACCEPT && !(te_d < tl_d)) begin
      oc_sel = OC_CLIP_EMPTY;
    end
    side_sel         = sided_q[DivStages-1];
    side_sel.outcome = oc_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
      vm_q <= 1'b0;
    end else if (en) begin
      vs_q <= vd_q[DivStages-1];
      vm_q <= vs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      te_q    <= te_d;
      tl_q    <= tl_d;
      sides_q <= side_sel;
      sidem_q <= sides_q;
    end
  end

  plc_lerp u_lerp_sx (.clk_i(clk_i), .en_i(en), .s_i(sides_q.x0), .d_i(sides_q.dx),
                      .t_i(te_q), .v_o(lerp_v[0]));
  plc_lerp u_lerp_sy (.clk_i(clk_i), .en_i(en), .s_i(sides_q.y0), .d_i(sides_q.dy),
                      .t_i(te_q), .v_o(lerp_v[1]));
  plc_lerp u_lerp_ex (.clk_i(clk_i), .en_i(en), .s_i(sides_q.x0), .d_i(sides_q.dx),
                      .t_i(tl_q), .v_o(lerp_v[2]));
  plc_lerp u_lerp_ey (.clk_i(clk_i), .en_i(en), .s_i(sides_q.y0), .d_i(sides_q.dy),
                      .t_i(tl_q), .v_o(lerp_v[3]));

  always_comb begin
    acc_d = 1'b0;
    csx_d = '0;
    csy_d = '0;
    cex_d = '0;
    cey_d = '0;
    case (sidem_q.outcome)
      OC_TRIV_ACCEPT: begin
        acc_d = 1'b1;
        csx_d = sidem_q.x0;
        csy_d = sidem_q.y0;
        cex_d = sidem_q.x1;
        cey_d = sidem_q.y1;
      end
      OC_CLIP_ACCEPT: begin
        acc_d = 1'b1;
        csx_d = lerp_v[0];
        csy_d = lerp_v[1];
        cex_d = lerp_v[2];
        cey_d = lerp_v[3];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      accepted_q <= acc_d;
      outcome_q  <= sidem_q.outcome;
      csx_q      <= csx_d;
      csy_q      <= csy_d;
      cex_q      <= cex_d;
      cey_q      <= cey_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = accepted_q;
  assign outcome_o         = outcome_q;
  assign clipped_start_x_o = csx_q;
  assign clipped_start_y_o = csy_q;
  assign clipped_end_x_o   = cex_q;
  assign clipped_end_y_o   = cey_q;

  a_accept_matches_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accepted_o == (outcome_q == OC_TRIV_ACCEPT ||
                                    outcome_q == OC_CLIP_ACCEPT)))
    else $error("accepted flag disagrees with outcome");

  a_reject_zero_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !accepted_o) |-> (clipped_start_x_o == '0 && clipped_start_y_o == '0 &&
                                      clipped_end_x_o == '0 && clipped_end_y_o == '0))
    else $error("rejected item carries coordinates");

  a_stall_only_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vm_q && out_valid_o && out_stall_i) |=> vm_q)
    else $error("pipeline item dropped during stall");

endmodule
